>>> sv/i2c_master_transaction_sequencer_unit_macros.svh
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer_unit_macros
// Assertion macros shared by the checker.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_UNIT_MACROS_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_UNIT_MACROS_SVH

// same-cycle implication, quiet during reset
`define I2CMTS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, quiet during reset
`define I2CMTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/i2cmts_pkg.sv
// ----------------------------------------------------------------------------
// i2cmts_pkg
// Types, codes and helpers shared by the i2c transaction sequencer modules.
// ----------------------------------------------------------------------------
package i2cmts_pkg;

	// request opcodes
	localparam logic [2:0] OP_POLL_READ  = 3'd0;
	localparam logic [2:0] OP_POLL_WRITE = 3'd1;
	localparam logic [2:0] OP_POLL_BOTH  = 3'd2;
	localparam logic [2:0] OP_COMMAND    = 3'd3;
	localparam logic [2:0] OP_WRITE      = 3'd4;
	localparam logic [2:0] OP_READ       = 3'd5;
	localparam logic [2:0] OP_REPORT     = 3'd6;
	localparam logic [2:0] OP_PAYLOAD    = 3'd7;

	// engine status codes after masking
	localparam logic [7:0] ST_MASK        = 8'hF8;
	localparam logic [7:0] ST_START       = 8'h08;
	localparam logic [7:0] ST_RESTART     = 8'h10;
	localparam logic [7:0] ST_SLA_W_ACK   = 8'h18;
	localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
	localparam logic [7:0] ST_SLA_R_ACK   = 8'h40;
	localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
	localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

	localparam logic [3:0] TEN_BIT_NIBBLE = 4'hF;

	localparam int QUEUE_DEPTH = 4;
	localparam int MAX_RESULTS = 4;

	typedef enum logic [2:0] {
		ACT_START   = 3'd0,
		ACT_SEND    = 3'd1,
		ACT_ACK     = 3'd2,
		ACT_NACK    = 3'd3,
		ACT_STOP    = 3'd4,
		ACT_RESET   = 3'd5,
		ACT_DELIVER = 3'd6,
		ACT_DONE    = 3'd7
	} act_t;

	typedef enum logic [3:0] {
		PH_IDLE         = 4'd0,
		PH_WAIT_START   = 4'd1,
		PH_WADDR_HI     = 4'd2,
		PH_WADDR_LO     = 4'd3,
		PH_RADDR_HI     = 4'd4,
		PH_RADDR_LO     = 4'd5,
		PH_DATA_ADDR    = 4'd6,
		PH_WANT_BYTE    = 4'd7,
		PH_TX           = 4'd8,
		PH_WAIT_RESTART = 4'd9,
		PH_RX           = 4'd10
	} phase_t;

	// all results caused by one request, as one queue entry
	typedef struct packed {
		logic [2:0]                   num;
		logic [MAX_RESULTS-1:0][2:0]  act;
		logic [MAX_RESULTS-1:0][7:0]  tx;
		logic [7:0]                   rx;
		logic                         ok;
		logic [15:0]                  cnt;
	} plan_t;

	function automatic plan_t plan_add(plan_t p, act_t a, logic [7:0] tx);
		plan_t r;
		r = p;
		r.act[p.num[1:0]] = a;
		r.tx[p.num[1:0]]  = tx;
		r.num = p.num + 3'd1;
		return r;
	endfunction

	// stop, engine reset, then done with status and count
	function automatic plan_t plan_finish(plan_t p, logic ok, logic [15:0] cnt);
		plan_t r;
		r = plan_add(p, ACT_STOP, 8'h00);
		r = plan_add(r, ACT_RESET, 8'h00);
		r = plan_add(r, ACT_DONE, 8'h00);
		r.ok  = ok;
		r.cnt = cnt;
		return r;
	endfunction

endpackage

>>> sv/i2cmts_front.sv
// ----------------------------------------------------------------------------
// i2cmts_front
// Transaction state machine: classifies each request and plans its results.
// ----------------------------------------------------------------------------
module i2cmts_front #(
	parameter int COUNT_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  logic [2:0]            opcode,
	input  logic [15:0]           target_address,
	input  logic [7:0]            register_address,
	input  logic [15:0]           byte_count,
	input  logic [7:0]            data_byte,
	input  logic [7:0]            engine_status,
	input  logic [7:0]            engine_rx_byte,
	output logic                  push,
	output i2cmts_pkg::plan_t     plan
);

	i2cmts_pkg::phase_t phase_q, phase_d;
	logic [2:0]            kind_q, kind_d;
	logic [15:0]           addr_q, addr_d;
	logic [7:0]            reg_q, reg_d;
	logic [COUNT_BITS-1:0] rem_q, rem_d;
	logic [COUNT_BITS-1:0] done_q, done_d;
	logic                  second_q, second_d;

	logic [7:0]  st;
	logic [15:0] raddr;
	logic [15:0] sel_addr;
	logic        sel_read;
	logic        is_hi;

	assign st    = engine_status & i2cmts_pkg::ST_MASK;
	assign raddr = addr_q | 16'h0001;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= i2cmts_pkg::PH_IDLE;
			kind_q   <= '0;
			addr_q   <= '0;
			reg_q    <= '0;
			rem_q    <= '0;
			done_q   <= '0;
			second_q <= 1'b0;
		end else if (take) begin
			phase_q  <= phase_d;
			kind_q   <= kind_d;
			addr_q   <= addr_d;
			reg_q    <= reg_d;
			rem_q    <= rem_d;
			done_q   <= done_d;
			second_q <= second_d;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		kind_d   = kind_q;
		addr_d   = addr_q;
		reg_d    = reg_q;
		rem_d    = rem_q;
		done_d   = done_q;
		second_d = second_q;
		plan     = '0;
		// address phase: restart and read polls use the read address
		sel_read = (phase_q == i2cmts_pkg::PH_WAIT_RESTART)
			|| (kind_q == i2cmts_pkg::OP_POLL_READ);
		sel_addr = sel_read ? raddr : addr_q;
		is_hi    = sel_addr[15:12] == i2cmts_pkg::TEN_BIT_NIBBLE;

		unique case (opcode) inside
			i2cmts_pkg::OP_POLL_READ, i2cmts_pkg::OP_POLL_WRITE, i2cmts_pkg::OP_POLL_BOTH,
			i2cmts_pkg::OP_COMMAND, i2cmts_pkg::OP_WRITE, i2cmts_pkg::OP_READ: begin
				if (phase_q == i2cmts_pkg::PH_IDLE) begin
					addr_d   = {target_address[14:0], 1'b0};
					reg_d    = (opcode == i2cmts_pkg::OP_COMMAND) ? data_byte : register_address;
					rem_d    = COUNT_BITS'(byte_count);
					done_d   = '0;
					second_d = opcode == i2cmts_pkg::OP_POLL_BOTH;
					kind_d   = (opcode == i2cmts_pkg::OP_POLL_BOTH) ?
						i2cmts_pkg::OP_POLL_READ : opcode;
					if (opcode == i2cmts_pkg::OP_READ && rem_d == '0) begin
						plan     = i2cmts_pkg::plan_add(plan, i2cmts_pkg::ACT_DONE, 8'h00);
						plan.ok  = 1'b1;
					end else begin
						plan    = i2cmts_pkg::plan_add(plan, i2cmts_pkg::ACT_START, 8'h00);
						phase_d = i2cmts_pkg::PH_WAIT_START;
					end
				end
			end
			i2cmts_pkg::OP_PAYLOAD: begin
				if (phase_q == i2cmts_pkg::PH_WANT_BYTE) begin
					plan    = i2cmts_pkg::plan_add(plan, i2cmts_pkg::ACT_SEND, data_byte);
					phase_d = i2cmts_pkg::PH_TX;
				end
			end
			i2cmts_pkg::OP_REPORT: begin
				unique case (phase_q)
					i2cmts_pkg::PH_WAIT_START, i2cmts_pkg::PH_WAIT_RESTART: begin
						if (st != ((phase_q == i2cmts_pkg::PH_WAIT_START) ?
								i2cmts_pkg::ST_START : i2cmts_pkg::ST_RESTART)) begin
							plan    = i2cmts_pkg::plan_finish(plan, 1'b0, 16'(done_q));
							phase_d = i2cmts_pkg::PH_IDLE;
						end else if (is_hi) begin
							plan    = i2cmts_pkg::plan_add(plan, i2cmts_pkg::ACT_SEND,
								sel_addr[15:8]);
							phase_d = sel_read ? i2cmts_pkg::PH_RADDR_HI :
								i2cmts_pkg::PH_WADDR_HI;
						end else begin
							plan    = i2cmts_pkg::plan_add(plan, i2cmts_pkg::ACT_SEND,
								sel_addr[7:0]);
							phase_d = sel_read ? i2cmts_pkg::PH_RADDR_LO :
								i2cmts_pkg::PH_WADDR_LO;
						end
					end
					i2cmts_pkg::PH_WADDR_HI: begin
						if (st != i2cmts_pkg::ST_SLA_W_ACK) begin
							plan    = i2cmts_pkg::plan_finish(plan, 1'b0, 16'(done_q));
							phase_d = i2cmts_pkg::PH_IDLE;
						end else begin
							plan    = i2cmts_pkg::plan_add(plan, i2cmts_pkg::ACT_SEND,
								addr_q[7:0]);
							phase_d = i2cmts_pkg::PH_WADDR_LO;
						end
					end
					i2cmts_pkg::PH_RADDR_HI: begin
						if (st != i2cmts_pkg::ST_SLA_R_ACK) begin
							plan    = i2cmts_pkg::plan_finish(plan, 1'b0, 16'(done_q));
							phase_d = i2cmts_pkg::PH_IDLE;
						end else begin
							plan    = i2cmts_pkg::plan_add(plan, i2cmts_pkg::ACT_SEND,
								raddr[7:0]);
							phase_d = i2cmts_pkg::PH_RADDR_LO;
						end
					end
					i2cmts_pkg::PH_WADDR_LO: begin
						phase_d = i2cmts_pkg::PH_IDLE;
						if (st != i2cmts_pkg::ST_SLA_W_ACK) begin
							plan = i2cmts_pkg::plan_finish(plan, 1'b0, 16'(done_q));
						end else if (kind_q == i2cmts_pkg::OP_COMMAND
								|| kind_q == i2cmts_pkg::OP_WRITE
								|| kind_q == i2cmts_pkg::OP_READ) begin
							plan    = i2cmts_pkg::plan_add(plan, i2cmts_pkg::ACT_SEND, reg_q);
							phase_d = i2cmts_pkg::PH_DATA_ADDR;
						end else begin
							plan = i2cmts_pkg::plan_finish(plan, 1'b1, 16'(done_q));
						end
					end
					i2cmts_pkg::PH_RADDR_LO: begin
						phase_d = i2cmts_pkg::PH_IDLE;
						if (st != i2cmts_pkg::ST_SLA_R_ACK) begin
							plan = i2cmts_pkg::plan_finish(plan, 1'b0, 16'(done_q));
						end else if (kind_q == i2cmts_pkg::OP_READ) begin
							plan    = i2cmts_pkg::plan_add(plan, (rem_q > COUNT_BITS'(1)) ?
								i2cmts_pkg::ACT_ACK : i2cmts_pkg::ACT_NACK, 8'h00);
							phase_d = i2cmts_pkg::PH_RX;
						end else if (second_q) begin
							// read poll passed, go on with the write poll
							second_d = 1'b0;
							kind_d   = i2cmts_pkg::OP_POLL_WRITE;
							plan     = i2cmts_pkg::plan_add(plan, i2cmts_pkg::ACT_STOP, 8'h00);
							plan     = i2cmts_pkg::plan_add(plan, i2cmts_pkg::ACT_RESET, 8'h00);
							plan     = i2cmts_pkg::plan_add(plan, i2cmts_pkg::ACT_START, 8'h00);
							phase_d  = i2cmts_pkg::PH_WAIT_START;
						end else begin
							plan = i2cmts_pkg::plan_finish(plan, 1'b1, 16'(done_q));
						end
					end
					i2cmts_pkg::PH_DATA_ADDR: begin
						phase_d = i2cmts_pkg::PH_IDLE;
						if (st != i2cmts_pkg::ST_DATA_W_ACK) begin
							plan = i2cmts_pkg::plan_finish(plan, 1'b0, 16'(done_q));
						end else if (kind_q == i2cmts_pkg::OP_READ) begin
							plan    = i2cmts_pkg::plan_add(plan, i2cmts_pkg::ACT_START, 8'h00);
							phase_d = i2cmts_pkg::PH_WAIT_RESTART;
						end else if (kind_q == i2cmts_pkg::OP_WRITE && rem_q != '0) begin
							phase_d = i2cmts_pkg::PH_WANT_BYTE;
						end else begin
							plan = i2cmts_pkg::plan_finish(plan, 1'b1, 16'(done_q));
						end
					end
					i2cmts_pkg::PH_TX: begin
						if (st != i2cmts_pkg::ST_DATA_W_ACK) begin
							plan    = i2cmts_pkg::plan_finish(plan, 1'b0, 16'(done_q));
							phase_d = i2cmts_pkg::PH_IDLE;
						end else begin
							done_d = done_q + COUNT_BITS'(1);
							rem_d  = rem_q - COUNT_BITS'(1);
							if (rem_d == '0) begin
								plan    = i2cmts_pkg::plan_finish(plan, 1'b1, 16'(done_d));
								phase_d = i2cmts_pkg::PH_IDLE;
							end else begin
								phase_d = i2cmts_pkg::PH_WANT_BYTE;
							end
						end
					end
					i2cmts_pkg::PH_RX: begin
						if (st != ((rem_q > COUNT_BITS'(1)) ?
								i2cmts_pkg::ST_DATA_R_ACK : i2cmts_pkg::ST_DATA_R_NACK)) begin
							plan    = i2cmts_pkg::plan_finish(plan, 1'b0, 16'(done_q));
							phase_d = i2cmts_pkg::PH_IDLE;
						end else begin
							plan    = i2cmts_pkg::plan_add(plan, i2cmts_pkg::ACT_DELIVER, 8'h00);
							plan.rx = engine_rx_byte;
							done_d  = done_q + COUNT_BITS'(1);
							rem_d   = rem_q - COUNT_BITS'(1);
							if (rem_d == '0) begin
								plan    = i2cmts_pkg::plan_finish(plan, 1'b1, 16'(done_d));
								phase_d = i2cmts_pkg::PH_IDLE;
							end else begin
								plan = i2cmts_pkg::plan_add(plan, (rem_d > COUNT_BITS'(1)) ?
									i2cmts_pkg::ACT_ACK : i2cmts_pkg::ACT_NACK, 8'h00);
							end
						end
					end
					default: begin
						// idle or waiting for a payload byte: report ignored
					end
				endcase
			end
		endcase
	end

	assign push = take && (plan.num != 3'd0);

endmodule

>>> sv/i2cmts_queue.sv
// ----------------------------------------------------------------------------
// i2cmts_queue
// Small first-in first-out queue of planned result groups.
// ----------------------------------------------------------------------------
module i2cmts_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  i2cmts_pkg::plan_t push_data,
	input  logic              pop,
	output i2cmts_pkg::plan_t head,
	output logic              empty,
	output logic              full
);

	localparam int PW = $clog2(i2cmts_pkg::QUEUE_DEPTH);

	i2cmts_pkg::plan_t entry_q [i2cmts_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [PW:0]   fill_q;

	assign empty = fill_q == '0;
	assign full  = fill_q == (PW+1)'(i2cmts_pkg::QUEUE_DEPTH);
	assign head  = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (PW+1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (PW+1)'(1);
			end
		end
	end

endmodule

>>> sv/i2cmts_back.sv
// ----------------------------------------------------------------------------
// i2cmts_back
// Walks the head result group and presents one result a cycle while out_ready is high.
// ----------------------------------------------------------------------------
module i2cmts_back (
	input  logic              clk,
	input  logic              arst_n,
	input  i2cmts_pkg::plan_t head,
	input  logic              empty,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        action,
	output logic [7:0]        tx_byte,
	output logic [7:0]        rx_byte,
	output logic              success,
	output logic [15:0]       processed_count,
	output logic              last
);

	logic [1:0] idx_q;
	logic [2:0] num_m1;
	logic       is_done;

	assign num_m1    = head.num - 3'd1;
	assign out_valid = !empty;
	assign action    = head.act[idx_q];
	assign tx_byte   = head.tx[idx_q];
	assign last      = idx_q == num_m1[1:0];
	assign is_done   = action == i2cmts_pkg::ACT_DONE;
	// rx and status fields only travel with their own action
	assign rx_byte         = (action == i2cmts_pkg::ACT_DELIVER) ? head.rx : 8'h00;
	assign success         = is_done && head.ok;
	assign processed_count = is_done ? head.cnt : 16'h0000;
	assign pop             = out_valid && out_ready && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (out_valid && out_ready) begin
			idx_q <= last ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

>>> sv/i2c_master_transaction_sequencer_unit.sv
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer_unit
// Transaction-level i2c master sequencing a byte-level bus engine.
// ----------------------------------------------------------------------------
// Usage:
// - in channel (in_valid/in_ready) takes requests, engine status reports and
//   write payload bytes; each is one request of the opcode field
// - out channel (out_valid/out_ready) gives engine actions, received bytes and
//   the final done result, zero to four results per request, last marking
//   the final one of its request
// - a request is handled in the cycle it is accepted; its results follow any
//   earlier groups at the output, one per cycle while out_ready is high
// - throughput: one request per cycle while the four-entry result queue has
//   room; a queue entry is popped when its last result is taken
// - when the receiver stalls, the queue fills and in_ready drops once it
//   holds four pending result groups; nothing is lost or reordered
// - reset puts the sequencer idle with all counters cleared and the queue
//   empty
module i2c_master_transaction_sequencer_unit #(
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic [15:0] target_address,
	input  logic [7:0]  register_address,
	input  logic [15:0] byte_count,
	input  logic [7:0]  data_byte,
	input  logic [7:0]  engine_status,
	input  logic [7:0]  engine_rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  action,
	output logic [7:0]  tx_byte,
	output logic [7:0]  rx_byte,
	output logic        success,
	output logic [15:0] processed_count,
	output logic        last
);

	i2cmts_pkg::plan_t plan;
	i2cmts_pkg::plan_t head;
	logic take;
	logic push;
	logic pop;
	logic empty;
	logic full;

	assign in_ready = !full;
	assign take     = in_valid && in_ready;

	i2cmts_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.take            (take),
		.opcode          (opcode),
		.target_address  (target_address),
		.register_address(register_address),
		.byte_count      (byte_count),
		.data_byte       (data_byte),
		.engine_status   (engine_status),
		.engine_rx_byte  (engine_rx_byte),
		.push            (push),
		.plan            (plan)
	);

	i2cmts_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(plan),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	i2cmts_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.empty          (empty),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.action         (action),
		.tx_byte        (tx_byte),
		.rx_byte        (rx_byte),
		.success        (success),
		.processed_count(processed_count),
		.last           (last)
	);

endmodule

>>> sv/i2cmts_checker.sv
// ----------------------------------------------------------------------------
// i2cmts_checker
// Port-level checks on the result channel of the sequencer.
// ----------------------------------------------------------------------------
`include "i2c_master_transaction_sequencer_unit_macros.svh"

module i2cmts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  action,
	input logic [7:0]  tx_byte,
	input logic [7:0]  rx_byte,
	input logic        success,
	input logic [15:0] processed_count,
	input logic        last
);

	// a stalled result holds
	`I2CMTS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(action) && $stable(tx_byte) && $stable(last), "stalled result changed")

	`I2CMTS_ASSERT_IMPL(a_tx_only_send, out_valid && action != i2cmts_pkg::ACT_SEND, tx_byte == 8'h00, "tx byte set outside send")

	`I2CMTS_ASSERT_IMPL(a_rx_only_deliver, out_valid && action != i2cmts_pkg::ACT_DELIVER, rx_byte == 8'h00, "rx byte set outside deliver")

	`I2CMTS_ASSERT_IMPL(a_done_fields, out_valid && action != i2cmts_pkg::ACT_DONE, !success && processed_count == 16'h0000, "status set outside done")

	// done always closes the results of its request
	`I2CMTS_ASSERT_IMPL(a_done_last, out_valid && action == i2cmts_pkg::ACT_DONE, last, "done not last of its request")

endmodule

bind i2c_master_transaction_sequencer_unit i2cmts_checker u_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.action         (action),
	.tx_byte        (tx_byte),
	.rx_byte        (rx_byte),
	.success        (success),
	.processed_count(processed_count),
	.last           (last)
);
